[hw/rtl/cne_pkg.sv]
// Shared types and constants for the calculator number entry block.
package cne_pkg;

    localparam int SYM_W         = 4;
    localparam int DISPLAY_SLOTS = 16;
    localparam int DISPLAY_W     = SYM_W * DISPLAY_SLOTS;
    localparam int LEN_W         = 5;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 4'd0;
    localparam logic [SYM_W-1:0] SYM_ONE   = 4'd1;
    localparam logic [SYM_W-1:0] SYM_NINE  = 4'd9;
    localparam logic [SYM_W-1:0] SYM_POINT = 4'd10;
    localparam logic [SYM_W-1:0] SYM_MINUS = 4'd11;
    localparam logic [SYM_W-1:0] SYM_E     = 4'd12;
    localparam logic [SYM_W-1:0] SYM_EMPTY = 4'd15;

    localparam logic [2:0] OP_DIGIT     = 3'd0;
    localparam logic [2:0] OP_POINT     = 3'd1;
    localparam logic [2:0] OP_SIGN      = 3'd2;
    localparam logic [2:0] OP_EXPONENT  = 3'd3;
    localparam logic [2:0] OP_BACKSPACE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_RESULT
    } cne_state_t;

    typedef enum logic [2:0] {
        PL_NONE,
        PL_PUSH,
        PL_INSERT,
        PL_REMOVE,
        PL_EXPSIGN
    } cne_plan_t;

    typedef enum logic [1:0] {
        MD_COPY,
        MD_SHIFTED,
        MD_SKIP
    } cne_mode_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] digit_value;
    } cne_key_t;

    typedef struct packed {
        logic                 accepted;
        logic                 emptied;
        logic                 entry_active;
        logic                 exponent_mode;
        logic [LEN_W-1:0]     buffer_length;
        logic [DISPLAY_W-1:0] display_symbols;
    } cne_result_t;

    typedef struct packed {
        logic             shift;
        logic [SYM_W-1:0] sym;
    } cne_ring_ctrl_t;

endpackage

[hw/rtl/cne_stream_if.sv]
// Valid/ready request channel carrying one payload of a chosen type.
interface cne_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/cne_symbol_ring.sv]
// Circular shift register of the typed symbols, one symbol per cycle when shifting.
module cne_symbol_ring #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cne_pkg::cne_ring_ctrl_t           ctrl,
    output logic [cne_pkg::SYM_W-1:0]         head,
    output logic [cne_pkg::DISPLAY_W-1:0]     display
);
    import cne_pkg::*;

    logic [SYM_W-1:0] cell_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                cell_reg[i] <= SYM_EMPTY;
            end
        end
        else if (ctrl.shift)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                cell_reg[i] <= cell_reg[i + 1];
            end
            cell_reg[DEPTH - 1] <= ctrl.sym;
        end
    end

    assign head = cell_reg[0];

    for (genvar g = 0; g < DISPLAY_SLOTS; g++)
    begin : g_slot
        if (g < DEPTH)
        begin : g_cell
            assign display[SYM_W*g +: SYM_W] = cell_reg[g];
        end
        else
        begin : g_pad
            assign display[SYM_W*g +: SYM_W] = SYM_EMPTY;
        end
    end
endmodule

[hw/rtl/cne_entry_ctrl.sv]
// Key sequencer: plans each edit, streams the ring once and updates the entry flags.
module cne_entry_ctrl #(
    parameter int DEPTH    = 16,
    parameter int MAX_MANT = 10,
    parameter int MAX_EXP  = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_valid,
    output logic                          key_ready,
    input  cne_pkg::cne_key_t             key_data,
    input  logic                          out_free,
    output logic                          out_load,
    output cne_pkg::cne_ring_ctrl_t       ring_ctrl,
    input  logic [cne_pkg::SYM_W-1:0]     ring_head,
    output logic                          accepted,
    output logic                          emptied,
    output logic                          entry_active,
    output logic                          exponent_mode,
    output logic [cne_pkg::LEN_W-1:0]     buffer_length
);
    import cne_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $clog2(MAX_EXP + 1);

    cne_state_t       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             point_reg, point_next;
    logic             inexp_reg, inexp_next;
    logic [EW-1:0]    edc_reg, edc_next;
    logic             neg_reg, neg_next;
    logic             active_reg, active_next;
    logic             emptied_reg, emptied_next;
    logic             acc_reg, acc_next;
    cne_plan_t        plan_reg, plan_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [SYM_W-1:0] sym_a_reg, sym_a_next;
    logic [SYM_W-1:0] sym_b_reg, sym_b_next;
    logic             two_reg, two_next;
    logic             gate_reg, gate_next;
    logic [2:0]       op_reg, op_next;
    logic [CW-1:0]    k_reg, k_next;
    cne_mode_t        mode_reg, mode_next;
    logic [SYM_W-1:0] carry_reg, carry_next;
    logic [SYM_W-1:0] h_reg, h_next;
    logic             eflag_reg, eflag_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    sig_reg, sig_next;
    logic             started_reg, started_next;
    logic [SYM_W-1:0] d_reg, d_next;
    logic             grow_reg, grow_next;
    logic [SYM_W-1:0] write_sym;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (key_valid) state_next = ST_SCAN;
            ST_SCAN:   if (k_reg == CW'(DEPTH)) state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_RESULT;
            ST_RESULT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        key_ready       = (state_reg == ST_IDLE);
        out_load        = (state_reg == ST_RESULT) && out_free;
        ring_ctrl.shift = (state_reg == ST_SCAN);
        ring_ctrl.sym   = write_sym;
    end

    always_comb
    begin
        logic             lead;
        logic [1:0]       need;
        logic [SYM_W-1:0] cur;
        logic [SYM_W-1:0] nxt;
        logic [SYM_W-1:0] w;
        logic             at_pos;
        logic             at_pos2;
        logic [CW-1:0]    new_count;

        count_next   = count_reg;
        point_next   = point_reg;
        inexp_next   = inexp_reg;
        edc_next     = edc_reg;
        neg_next     = neg_reg;
        active_next  = active_reg;
        emptied_next = emptied_reg;
        acc_next     = acc_reg;
        plan_next    = plan_reg;
        pos_next     = pos_reg;
        sym_a_next   = sym_a_reg;
        sym_b_next   = sym_b_reg;
        two_next     = two_reg;
        gate_next    = gate_reg;
        op_next      = op_reg;
        k_next       = k_reg;
        mode_next    = mode_reg;
        carry_next   = carry_reg;
        h_next       = h_reg;
        eflag_next   = eflag_reg;
        done_next    = done_reg;
        sig_next     = sig_reg;
        started_next = started_reg;
        d_next       = d_reg;
        grow_next    = grow_reg;
        write_sym    = SYM_EMPTY;
        lead         = 1'b0;
        need         = 2'd1;
        cur          = h_reg;
        nxt          = (k_reg == CW'(DEPTH)) ? SYM_EMPTY : ring_head;
        at_pos       = (k_reg == pos_reg + CW'(1));
        at_pos2      = (k_reg == pos_reg + CW'(2));
        new_count    = count_reg;
        w            = cur;

        case (state_reg)
            ST_IDLE:
            begin
                if (key_valid)
                begin
                    plan_next    = PL_NONE;
                    pos_next     = count_reg;
                    sym_a_next   = SYM_EMPTY;
                    sym_b_next   = SYM_EMPTY;
                    two_next     = 1'b0;
                    gate_next    = 1'b0;
                    op_next      = key_data.opcode;
                    k_next       = '0;
                    mode_next    = MD_COPY;
                    eflag_next   = 1'b0;
                    done_next    = 1'b0;
                    sig_next     = '0;
                    started_next = 1'b0;
                    acc_next     = 1'b0;
                    grow_next    = 1'b0;
                    emptied_next = 1'b0;
                    case (key_data.opcode)
                        OP_DIGIT:
                        begin
                            if (key_data.digit_value <= SYM_NINE)
                            begin
                                active_next = 1'b1;
                                sym_a_next  = key_data.digit_value;
                                if (inexp_reg)
                                begin
                                    if (edc_reg < EW'(MAX_EXP) && count_reg < CW'(DEPTH))
                                        plan_next = PL_PUSH;
                                end
                                else
                                begin
                                    gate_next = 1'b1;
                                    if (count_reg < CW'(DEPTH))
                                        plan_next = PL_PUSH;
                                end
                            end
                        end
                        OP_POINT:
                        begin
                            active_next = 1'b1;
                            lead = (count_reg == '0) ||
                                   (count_reg == CW'(1) && ring_head == SYM_MINUS);
                            need = lead ? 2'd2 : 2'd1;
                            if (!inexp_reg && !point_reg &&
                                (CW+1)'(count_reg) + (CW+1)'(need) <= (CW+1)'(DEPTH))
                            begin
                                plan_next  = PL_PUSH;
                                sym_a_next = lead ? SYM_ZERO : SYM_POINT;
                                sym_b_next = SYM_POINT;
                                two_next   = lead;
                            end
                        end
                        OP_SIGN:
                        begin
                            if (inexp_reg)
                            begin
                                plan_next = PL_EXPSIGN;
                            end
                            else
                            begin
                                active_next = 1'b1;
                                pos_next    = '0;
                                if (ring_head == SYM_MINUS)
                                begin
                                    plan_next = PL_REMOVE;
                                end
                                else if (count_reg < CW'(DEPTH))
                                begin
                                    plan_next  = PL_INSERT;
                                    sym_a_next = SYM_MINUS;
                                end
                            end
                        end
                        OP_EXPONENT:
                        begin
                            if (!inexp_reg)
                            begin
                                active_next = 1'b1;
                                lead = (count_reg == '0);
                                need = lead ? 2'd2 : 2'd1;
                                if ((CW+1)'(count_reg) + (CW+1)'(need) <= (CW+1)'(DEPTH))
                                begin
                                    plan_next  = PL_PUSH;
                                    sym_a_next = lead ? SYM_ONE : SYM_E;
                                    sym_b_next = SYM_E;
                                    two_next   = lead;
                                end
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (count_reg == '0)
                            begin
                                active_next  = 1'b0;
                                emptied_next = 1'b1;
                            end
                            else
                            begin
                                plan_next = PL_REMOVE;
                                pos_next  = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            plan_next = PL_NONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                k_next = k_reg + CW'(1);
                h_next = ring_head;
                if (k_reg != '0)
                begin
                    case (mode_reg)
                        MD_SHIFTED:
                        begin
                            w          = carry_reg;
                            carry_next = cur;
                        end
                        MD_SKIP: w = nxt;
                        default: w = cur;
                    endcase
                    case (plan_reg)
                        PL_PUSH:
                        begin
                            if (at_pos && (!gate_reg || sig_reg < CW'(MAX_MANT)))
                            begin
                                w        = sym_a_reg;
                                acc_next = 1'b1;
                            end
                            if (two_reg && at_pos2)
                                w = sym_b_reg;
                        end
                        PL_INSERT:
                        begin
                            if (at_pos)
                            begin
                                w          = sym_a_reg;
                                carry_next = cur;
                                mode_next  = MD_SHIFTED;
                                acc_next   = 1'b1;
                            end
                        end
                        PL_REMOVE:
                        begin
                            if (at_pos)
                            begin
                                w         = nxt;
                                mode_next = MD_SKIP;
                                d_next    = cur;
                                acc_next  = 1'b1;
                            end
                        end
                        PL_EXPSIGN:
                        begin
                            if (eflag_reg && !done_reg)
                            begin
                                done_next = 1'b1;
                                if (cur == SYM_MINUS)
                                begin
                                    w         = nxt;
                                    mode_next = MD_SKIP;
                                    acc_next  = 1'b1;
                                    grow_next = 1'b0;
                                end
                                else if (count_reg < CW'(DEPTH))
                                begin
                                    w          = SYM_MINUS;
                                    carry_next = cur;
                                    mode_next  = MD_SHIFTED;
                                    acc_next   = 1'b1;
                                    grow_next  = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    write_sym  = w;
                    eflag_next = (cur == SYM_E);
                    if (cur <= SYM_NINE && (started_reg || cur != SYM_ZERO))
                    begin
                        sig_next     = sig_reg + CW'(1);
                        started_next = 1'b1;
                    end
                end
            end
            ST_APPLY:
            begin
                if (acc_reg)
                begin
                    case (plan_reg)
                        PL_PUSH:
                        begin
                            count_next = count_reg + (two_reg ? CW'(2) : CW'(1));
                            if (op_reg == OP_DIGIT && inexp_reg)
                                edc_next = edc_reg + EW'(1);
                            if (op_reg == OP_POINT)
                                point_next = 1'b1;
                            if (op_reg == OP_EXPONENT)
                            begin
                                inexp_next = 1'b1;
                                edc_next   = '0;
                                neg_next   = 1'b0;
                            end
                        end
                        PL_INSERT:
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        PL_REMOVE:
                        begin
                            new_count  = count_reg - CW'(1);
                            count_next = new_count;
                            if (op_reg == OP_BACKSPACE)
                            begin
                                if (d_reg == SYM_POINT)
                                    point_next = 1'b0;
                                if (d_reg == SYM_E)
                                begin
                                    inexp_next = 1'b0;
                                    edc_next   = '0;
                                    neg_next   = 1'b0;
                                end
                                else if (inexp_reg && d_reg == SYM_MINUS)
                                begin
                                    neg_next = 1'b0;
                                end
                                else if (inexp_reg && d_reg <= SYM_NINE && edc_reg != '0)
                                begin
                                    edc_next = edc_reg - EW'(1);
                                end
                                if (new_count == '0)
                                begin
                                    active_next  = 1'b0;
                                    emptied_next = 1'b1;
                                end
                            end
                        end
                        PL_EXPSIGN:
                        begin
                            count_next = grow_reg ? count_reg + CW'(1) : count_reg - CW'(1);
                            neg_next   = grow_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            point_reg   <= 1'b0;
            inexp_reg   <= 1'b0;
            edc_reg     <= '0;
            neg_reg     <= 1'b0;
            active_reg  <= 1'b0;
            emptied_reg <= 1'b0;
            acc_reg     <= 1'b0;
            plan_reg    <= PL_NONE;
            k_reg       <= '0;
            mode_reg    <= MD_COPY;
            eflag_reg   <= 1'b0;
            done_reg    <= 1'b0;
            sig_reg     <= '0;
            started_reg <= 1'b0;
            grow_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            point_reg   <= point_next;
            inexp_reg   <= inexp_next;
            edc_reg     <= edc_next;
            neg_reg     <= neg_next;
            active_reg  <= active_next;
            emptied_reg <= emptied_next;
            acc_reg     <= acc_next;
            plan_reg    <= plan_next;
            k_reg       <= k_next;
            mode_reg    <= mode_next;
            eflag_reg   <= eflag_next;
            done_reg    <= done_next;
            sig_reg     <= sig_next;
            started_reg <= started_next;
            grow_reg    <= grow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        sym_a_reg <= sym_a_next;
        sym_b_reg <= sym_b_next;
        two_reg   <= two_next;
        gate_reg  <= gate_next;
        op_reg    <= op_next;
        carry_reg <= carry_next;
        h_reg     <= h_next;
        d_reg     <= d_next;
    end

    assign accepted      = acc_reg;
    assign emptied       = emptied_reg;
    assign entry_active  = active_reg;
    assign exponent_mode = inexp_reg;
    assign buffer_length = LEN_W'(count_reg);
endmodule

[hw/rtl/calculator_number_entry.sv]
// Top level of the calculator number entry block with its result register.
//
// The key channel takes one key request: an opcode (digit, point, change sign,
// exponent or backspace) and a digit value. The result channel returns exactly
// one request per key with the accepted and emptied bits, the entry flags, the
// buffer length and the packed display symbols.
// A key is taken only while the block is idle. Each key streams the symbol ring
// once, one symbol per cycle, then applies the edit and loads the result
// register. The block takes no new key until the last key's result has been
// loaded, so keys are handled one at a time.
// Reset empties the buffer, clears all flags and drops any pending result.
// While the receiver stalls, the result register holds its request and a key
// already taken runs to completion, then waits until the register is free.
module calculator_number_entry #(
    parameter int BUFFER_DEPTH        = 16,
    parameter int MAX_MANTISSA_DIGITS = 10,
    parameter int MAX_EXPONENT_DIGITS = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    cne_stream_if.sink    key,
    cne_stream_if.source  result
);
    import cne_pkg::*;

    cne_key_t         key_data;
    cne_ring_ctrl_t   ring_ctrl;
    logic [SYM_W-1:0] ring_head;
    logic [DISPLAY_W-1:0] display;
    logic             out_free;
    logic             out_load;
    logic             accepted;
    logic             emptied;
    logic             entry_active;
    logic             exponent_mode;
    logic [LEN_W-1:0] buffer_length;
    logic             result_valid_reg;
    cne_result_t      result_data_reg;

    assign key_data = key.payload;
    assign out_free = !result_valid_reg || result.ready;

    cne_entry_ctrl #(
        .DEPTH    (BUFFER_DEPTH),
        .MAX_MANT (MAX_MANTISSA_DIGITS),
        .MAX_EXP  (MAX_EXPONENT_DIGITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key.valid),
        .key_ready     (key.ready),
        .key_data      (key_data),
        .out_free      (out_free),
        .out_load      (out_load),
        .ring_ctrl     (ring_ctrl),
        .ring_head     (ring_head),
        .accepted      (accepted),
        .emptied       (emptied),
        .entry_active  (entry_active),
        .exponent_mode (exponent_mode),
        .buffer_length (buffer_length)
    );

    cne_symbol_ring #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ring_ctrl),
        .head    (ring_head),
        .display (display)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_data_reg.accepted        <= accepted;
            result_data_reg.emptied         <= emptied;
            result_data_reg.entry_active    <= entry_active;
            result_data_reg.exponent_mode   <= exponent_mode;
            result_data_reg.buffer_length   <= buffer_length;
            result_data_reg.display_symbols <= display;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_data_reg;
endmodule

[test/calculator_number_entry_tb.sv]
// Self-checking testbench for calculator_number_entry: directed key table, then random key runs.
module calculator_number_entry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cne_pkg::*;

    localparam int DEPTH         = 16;
    localparam int MANT_LIMIT    = 10;
    localparam int EXP_LIMIT     = 2;
    localparam int RANDOM_KEYS   = 1900;
    localparam int PHASES        = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 4 * (DEPTH + 3);
    localparam int DIRECTED_ROWS = 22;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;
    localparam logic [3:0] DIGIT_MAX_CODE  = 4'd15;

    localparam logic [DISPLAY_W-1:0] ALL_EMPTY = {DISPLAY_SLOTS{SYM_EMPTY}};
    localparam cne_result_t NO_RESULT = '0;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  dig;
        logic        typed;
        cne_result_t res;
    } key_row_t;

    key_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_BACKSPACE, 4'd0, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 5'd0, ALL_EMPTY}},
        '{OP_LAST_UNUSED, 4'd9, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd0, ALL_EMPTY}},
        '{OP_DIGIT, DIGIT_MAX_CODE, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 5'd0, ALL_EMPTY}},
        '{OP_EXPONENT, 4'd0, 1'b1,
          '{1'b1, 1'b0, 1'b1, 1'b1, 5'd2, 64'hFFFF_FFFF_FFFF_FFC1}},
        '{OP_DIGIT, 4'd9, 1'b0, NO_RESULT},
        '{OP_DIGIT, 4'd0, 1'b0, NO_RESULT},
        '{OP_DIGIT, 4'd5, 1'b0, NO_RESULT},
        '{OP_POINT, 4'd0, 1'b0, NO_RESULT},
        '{OP_SIGN, 4'd0, 1'b0, NO_RESULT},
        '{OP_EXPONENT, 4'd0, 1'b0, NO_RESULT},
        '{OP_BACKSPACE, 4'd0, 1'b0, NO_RESULT},
        '{OP_BACKSPACE, 4'd0, 1'b0, NO_RESULT},
        '{OP_BACKSPACE, 4'd0, 1'b0, NO_RESULT},
        '{OP_BACKSPACE, 4'd0, 1'b0, NO_RESULT},
        '{OP_BACKSPACE, 4'd0, 1'b0, NO_RESULT},
        '{OP_SIGN, 4'd0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 5'd1, 64'hFFFF_FFFF_FFFF_FFFB}},
        '{OP_POINT, 4'd0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 5'd3, 64'hFFFF_FFFF_FFFF_FA0B}},
        '{OP_POINT, 4'd0, 1'b0, NO_RESULT},
        '{OP_SIGN, 4'd0, 1'b0, NO_RESULT},
        '{OP_FIRST_UNUSED, DIGIT_MAX_CODE, 1'b0, NO_RESULT},
        '{OP_BACKSPACE, 4'd0, 1'b0, NO_RESULT},
        '{OP_BACKSPACE, 4'd0, 1'b0, NO_RESULT}
    };

    logic clk;
    logic rst_n;

    cne_stream_if #(.payload_t(cne_key_t))    key_ch ();
    cne_stream_if #(.payload_t(cne_result_t)) res_ch ();

    calculator_number_entry #(
        .BUFFER_DEPTH        (DEPTH),
        .MAX_MANTISSA_DIGITS (MANT_LIMIT),
        .MAX_EXPONENT_DIGITS (EXP_LIMIT)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_ch),
        .result (res_ch)
    );

    logic [SYM_W-1:0] entry_syms [DEPTH];
    int  entry_len;
    bit  entry_point;
    bit  entry_in_exp;
    bit  entry_exp_neg;
    bit  entry_active;
    int  entry_exp_digits;

    cne_result_t pending_results [$];
    int idle_pct  = 0;
    int stall_pct = 0;
    int errors    = 0;
    int results_seen = 0;

    function automatic bit push_symbol(logic [SYM_W-1:0] s);
        if (entry_len >= DEPTH) return 1'b0;
        entry_syms[entry_len] = s;
        entry_len++;
        return 1'b1;
    endfunction

    function automatic bit insert_symbol(int pos, logic [SYM_W-1:0] s);
        int i;
        if (entry_len >= DEPTH || pos > entry_len) return 1'b0;
        for (i = entry_len; i > pos; i--) entry_syms[i] = entry_syms[i-1];
        entry_syms[pos] = s;
        entry_len++;
        return 1'b1;
    endfunction

    function automatic void remove_symbol(int pos);
        int i;
        if (pos >= entry_len) return;
        for (i = pos; i + 1 < entry_len; i++) entry_syms[i] = entry_syms[i+1];
        entry_len--;
        entry_syms[entry_len] = SYM_EMPTY;
    endfunction

    function automatic int mantissa_digits();
        int  i;
        int  n;
        bit  started;
        n = 0;
        started = 1'b0;
        for (i = 0; i < entry_len; i++) begin
            if (entry_syms[i] > SYM_NINE) continue;
            if (!started && entry_syms[i] == SYM_ZERO) continue;
            started = 1'b1;
            n++;
        end
        return n;
    endfunction

    function automatic void clear_entry();
        int i;
        for (i = 0; i < DEPTH; i++) entry_syms[i] = SYM_EMPTY;
        entry_len = 0;
        entry_point = 1'b0;
        entry_in_exp = 1'b0;
        entry_exp_neg = 1'b0;
        entry_active = 1'b0;
        entry_exp_digits = 0;
    endfunction

    function automatic cne_result_t predict_key(cne_key_t k);
        cne_result_t      r;
        bit               ok;
        bit               emptied;
        bit               lead;
        int               e;
        int               i;
        logic [SYM_W-1:0] d;
        ok = 1'b0;
        emptied = 1'b0;
        case (k.opcode)
            OP_DIGIT:
            begin
                if (k.digit_value <= SYM_NINE)
                begin
                    entry_active = 1'b1;
                    if (entry_in_exp)
                    begin
                        if (entry_exp_digits < EXP_LIMIT && push_symbol(k.digit_value))
                        begin
                            entry_exp_digits = (entry_exp_digits + 1) & 3;
                            ok = 1'b1;
                        end
                    end
                    else if (mantissa_digits() < MANT_LIMIT)
                    begin
                        ok = push_symbol(k.digit_value);
                    end
                end
            end
            OP_POINT:
            begin
                entry_active = 1'b1;
                if (!entry_in_exp && !entry_point)
                begin
                    lead = entry_len == 0 || (entry_len == 1 && entry_syms[0] == SYM_MINUS);
                    if (entry_len + (lead ? 2 : 1) <= DEPTH)
                    begin
                        if (lead) void'(push_symbol(SYM_ZERO));
                        void'(push_symbol(SYM_POINT));
                        entry_point = 1'b1;
                        ok = 1'b1;
                    end
                end
            end
            OP_SIGN:
            begin
                if (entry_in_exp)
                begin
                    e = 0;
                    while (e < entry_len && entry_syms[e] != SYM_E) e++;
                    if (e < entry_len)
                    begin
                        if (e + 1 < entry_len && entry_syms[e+1] == SYM_MINUS)
                        begin
                            remove_symbol(e + 1);
                            entry_exp_neg = 1'b0;
                            ok = 1'b1;
                        end
                        else if (insert_symbol(e + 1, SYM_MINUS))
                        begin
                            entry_exp_neg = 1'b1;
                            ok = 1'b1;
                        end
                    end
                end
                else
                begin
                    entry_active = 1'b1;
                    if (entry_len == 0)
                    begin
                        ok = push_symbol(SYM_MINUS);
                    end
                    else if (entry_syms[0] == SYM_MINUS)
                    begin
                        remove_symbol(0);
                        ok = 1'b1;
                    end
                    else
                    begin
                        ok = insert_symbol(0, SYM_MINUS);
                    end
                end
            end
            OP_EXPONENT:
            begin
                if (!entry_in_exp)
                begin
                    entry_active = 1'b1;
                    lead = entry_len == 0;
                    if (entry_len + (lead ? 2 : 1) <= DEPTH)
                    begin
                        if (lead) void'(push_symbol(SYM_ONE));
                        void'(push_symbol(SYM_E));
                        entry_in_exp = 1'b1;
                        entry_exp_digits = 0;
                        entry_exp_neg = 1'b0;
                        ok = 1'b1;
                    end
                end
            end
            OP_BACKSPACE:
            begin
                if (entry_len == 0)
                begin
                    entry_active = 1'b0;
                    emptied = 1'b1;
                end
                else
                begin
                    d = entry_syms[entry_len-1];
                    remove_symbol(entry_len - 1);
                    if (d == SYM_POINT) entry_point = 1'b0;
                    if (d == SYM_E)
                    begin
                        entry_in_exp = 1'b0;
                        entry_exp_digits = 0;
                        entry_exp_neg = 1'b0;
                    end
                    else if (entry_in_exp && d == SYM_MINUS)
                    begin
                        entry_exp_neg = 1'b0;
                    end
                    else if (entry_in_exp && d <= SYM_NINE && entry_exp_digits > 0)
                    begin
                        entry_exp_digits--;
                    end
                    if (entry_len == 0)
                    begin
                        entry_active = 1'b0;
                        emptied = 1'b1;
                    end
                    ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.accepted = ok;
        r.emptied = emptied;
        r.entry_active = entry_active;
        r.exponent_mode = entry_in_exp;
        r.buffer_length = entry_len[LEN_W-1:0];
        for (i = 0; i < DISPLAY_SLOTS; i++)
            r.display_symbols[SYM_W*i +: SYM_W] = (i < entry_len) ? entry_syms[i] : SYM_EMPTY;
        return r;
    endfunction

    task automatic send_key(input cne_key_t k);
        while ($urandom_range(99) < idle_pct)
        begin
            key_ch.valid <= 1'b0;
            @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.payload <= k;
        @(posedge clk);
        while (!key_ch.ready) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : result_sink
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        cne_result_t want;
        cne_result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.payload;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: acc=%0b emp=%0b act=%0b exp=%0b len=%0d sym=%h",
                             got.accepted, got.emptied, got.entry_active, got.exponent_mode,
                             got.buffer_length, got.display_symbols);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.accepted !== want.accepted || got.emptied !== want.emptied ||
                    got.entry_active !== want.entry_active ||
                    got.exponent_mode !== want.exponent_mode ||
                    got.buffer_length !== want.buffer_length ||
                    got.display_symbols !== want.display_symbols)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $display("result %0d expected: acc=%0b emp=%0b act=%0b exp=%0b len=%0d sym=%h",
                                 results_seen, want.accepted, want.emptied, want.entry_active,
                                 want.exponent_mode, want.buffer_length, want.display_symbols);
                        $display("result %0d actual:   acc=%0b emp=%0b act=%0b exp=%0b len=%0d sym=%h",
                                 results_seen, got.accepted, got.emptied, got.entry_active,
                                 got.exponent_mode, got.buffer_length, got.display_symbols);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("calculator_number_entry_tb: errors");
        $finish;
    end

    initial
    begin : key_driver
        cne_key_t    k;
        cne_result_t r;
        int          i;
        int          phase;
        int          sent;
        int          roll;
        int          bs_bias;
        int          rejected;
        int          full_hits;
        bit          clearing;
        bit          noise;
        key_ch.valid <= 1'b0;
        key_ch.payload <= '0;
        clear_entry();
        rejected = 0;
        full_hits = 0;
        clearing = 1'b0;
        bs_bias = 12;
        wait (rst_n === 1'b1);
        @(posedge clk);

        for (i = 0; i < DIRECTED_ROWS; i++)
        begin
            k.opcode = directed_rows[i].op;
            k.digit_value = directed_rows[i].dig;
            send_key(k);
            r = predict_key(k);
            if (directed_rows[i].typed) r = directed_rows[i].res;
            pending_results.insert(pending_results.size(), r);
            if (!r.accepted) rejected++;
        end

        sent = 0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            idle_pct  = (phase == 1) ? 58 : (phase == 3) ? 33 : 0;
            stall_pct = (phase == 2) ? 58 : (phase == 3) ? 33 : 0;
            while (sent < RANDOM_KEYS * (phase + 1) / PHASES)
            begin
                k.digit_value = 4'($urandom_range(15));
                noise = 1'b0;
                if (clearing)
                begin
                    k.opcode = OP_BACKSPACE;
                    if (entry_len == 0)
                    begin
                        clearing = 1'b0;
                        bs_bias = $urandom_range(25, 3);
                    end
                end
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 4)
                    begin
                        noise = 1'b1;
                        if ($urandom_range(1))
                        begin
                            k.opcode = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
                        end
                        else
                        begin
                            k.opcode = OP_DIGIT;
                            k.digit_value = 4'($urandom_range(DIGIT_MAX_CODE, SYM_POINT));
                        end
                    end
                    else if (roll < 4 + bs_bias)
                        k.opcode = OP_BACKSPACE;
                    else if (roll < 12 + bs_bias)
                        k.opcode = OP_POINT;
                    else if (roll < 20 + bs_bias)
                        k.opcode = OP_SIGN;
                    else if (roll < 27 + bs_bias)
                        k.opcode = OP_EXPONENT;
                    else
                    begin
                        k.opcode = OP_DIGIT;
                        k.digit_value = ($urandom_range(3) == 0) ? SYM_ZERO :
                                        4'($urandom_range(9));
                    end
                    if ((entry_len == DEPTH && $urandom_range(3) == 0) || $urandom_range(99) < 2)
                        clearing = 1'b1;
                end
                send_key(k);
                r = predict_key(k);
                pending_results.insert(pending_results.size(), r);
                if (!r.accepted) rejected++;
                if (r.buffer_length == DEPTH) full_hits++;
                if (!noise) sent++;
            end
        end
        key_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d directed and %0d random keys over four flow-control phases, %0d results checked",
                 DIRECTED_ROWS, sent, results_seen);
        $display("%0d keys left the entry unchanged, %0d results showed a full buffer",
                 rejected, full_hits);
        if (errors == 0)
            $display("calculator_number_entry_tb: clean");
        else
            $display("calculator_number_entry_tb: errors");
        $finish;
    end

endmodule
